/* rtl/ctfc_pkg.sv */
// Package for the CAN test frame checker: item type, status codes, DLC table
// and the frame evaluation function. No dependencies.
package ctfc_pkg;

    localparam int unsigned MAX_PAYLOAD = 64;
    localparam int unsigned LEN_W       = 7;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_DLC      = 3'd3,
        ST_ID_MID   = 3'd4,
        ST_ID_TOP   = 3'd5
    } t_status;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_DATA   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic        opcode;
        logic [28:0] frame_ident;
        logic [7:0]  data_length;
        logic        extended_frame;
        logic [7:0]  payload_byte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    // DLC code for lengths of eight and more, indexed by (length - 8) / 4.
    localparam logic [3:0] DLC_TABLE [16] = '{
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0, 4'd13, 4'd0,
        4'd0, 4'd0, 4'd14, 4'd0, 4'd0, 4'd0, 4'd15, 4'd0
    };

    function automatic logic [3:0] length_code(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] diff;
        diff = len - LEN_W'(8);
        if (len < LEN_W'(8)) begin
            return len[3:0];
        end
        return DLC_TABLE[diff[5:2]];
    endfunction

    // The first failing check decides the status.
    function automatic t_status evaluate(input logic [28:0] ident,
                                         input logic [LEN_W-1:0] len,
                                         input logic ext,
                                         input logic [6:0] x);
        t_status st;
        priority if (ident[6:0] != x) begin
            st = ST_CHECKSUM;
        end else if (ident[10:7] != length_code(len)) begin
            st = ST_DLC;
        end else if (!ext) begin
            st = ST_OK;
        end else if (ident[21:11] != ident[10:0]) begin
            st = ST_ID_MID;
        end else if (ident[28:22] != ident[6:0]) begin
            st = ST_ID_TOP;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

/* rtl/ctfc_if.sv */
// Valid/ready channel interfaces for the CAN test frame checker.
// Requests carry a frame header or one payload byte; results carry a status.
interface ctfc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [28:0] frame_ident;
    logic [7:0]  data_length;
    logic        extended_frame;
    logic [7:0]  payload_byte;

    modport source (output valid, opcode, frame_ident, data_length, extended_frame,
                    payload_byte, input ready);
    modport sink   (input valid, opcode, frame_ident, data_length, extended_frame,
                    payload_byte, output ready);
endinterface

interface ctfc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] check_status;
    logic       frame_good;

    modport source (output valid, check_status, frame_good, input ready);
    modport sink   (input valid, check_status, frame_good, output ready);
endinterface

/* rtl/ctfc_in_reg.sv */
// Input register of the CAN test frame checker. Uses ctfc_pkg and ctfc_in_if.
// Holds one request until the check stage takes it.
module ctfc_in_reg
    import ctfc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctfc_in_if.sink       i_item,
    input  logic          i_advance,
    output t_stage        o_stage
);

    logic  r_valid;
    t_item r_item;
    logic  take;

    // No request is accepted while reset is held.
    assign i_item.ready = i_rst_n && (!r_valid || i_advance);
    assign take         = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.opcode         <= i_item.opcode;
            r_item.frame_ident    <= i_item.frame_ident;
            r_item.data_length    <= i_item.data_length;
            r_item.extended_frame <= i_item.extended_frame;
            r_item.payload_byte   <= i_item.payload_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

/* rtl/ctfc_check.sv */
// Frame tracking, checks and result register of the CAN test frame checker.
// Uses ctfc_pkg and ctfc_out_if.
module ctfc_check
    import ctfc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stage        i_stage,
    output logic          o_advance,
    ctfc_out_if.source    o_result
);

    logic [28:0]      r_held_ident;
    logic [LEN_W-1:0] r_held_length;
    logic             r_held_ext;
    logic [LEN_W-1:0] r_remaining;
    logic [6:0]       r_xor;
    logic             r_open;
    logic             r_out_valid;
    t_status          r_status;

    logic [6:0]       n_xor;
    logic [LEN_W-1:0] n_remaining;
    logic             emit;
    t_status          n_status;
    logic             is_header;
    logic             too_long;
    logic             zero_len;

    assign o_advance = i_stage.valid && (!r_out_valid || o_result.ready);

    assign is_header   = (i_stage.item.opcode == OP_HEADER);
    assign too_long    = i_stage.item.data_length > 8'(MAX_PAYLOAD);
    assign zero_len    = i_stage.item.data_length == 8'd0;
    assign n_xor       = r_xor ^ i_stage.item.payload_byte[6:0];
    assign n_remaining = r_remaining - LEN_W'(1);

    always_comb begin
        emit     = 1'b0;
        n_status = ST_OK;
        if (is_header) begin
            if (too_long) begin
                emit     = 1'b1;
                n_status = ST_LENGTH;
            end else if (zero_len) begin
                emit     = 1'b1;
                n_status = evaluate(i_stage.item.frame_ident, '0,
                                    i_stage.item.extended_frame, 7'd0);
            end
        end else if (r_open && n_remaining == '0) begin
            emit     = 1'b1;
            n_status = evaluate(r_held_ident, r_held_length, r_held_ext, n_xor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                if (is_header) begin
                    r_open <= !too_long && !zero_len;
                end else if (r_open && n_remaining == '0) begin
                    r_open <= 1'b0;
                end
            end
            if (o_advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_ident  <= '0;
            r_held_length <= '0;
            r_held_ext    <= 1'b0;
            r_remaining   <= '0;
            r_xor         <= '0;
        end else if (o_advance) begin
            if (is_header) begin
                if (!too_long && !zero_len) begin
                    r_held_ident  <= i_stage.item.frame_ident;
                    r_held_length <= i_stage.item.data_length[LEN_W-1:0];
                    r_held_ext    <= i_stage.item.extended_frame;
                    r_remaining   <= i_stage.item.data_length[LEN_W-1:0];
                    r_xor         <= '0;
                end
            end else if (r_open) begin
                r_xor       <= n_xor;
                r_remaining <= n_remaining;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && emit) begin
            r_status <= n_status;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.check_status = r_status;
    assign o_result.frame_good   = (r_status == ST_OK);

endmodule

/* rtl/can_test_frame_checker_unit.sv */
// A result is registered in order: the request that completes its frame is held in the
// input register, then its status is loaded into the result register.
// Throughput: one request per cycle; the check stage consumes a request whenever
// the result register is empty or being read in the same cycle.
// Reset: synchronous, active low; clears the open frame, the held header and the
// running XOR, empties both the input and the result register, and holds ready low.
//
// Top level of the CAN test frame checker. Uses ctfc_pkg, ctfc_in_if,
// ctfc_out_if, ctfc_in_reg and ctfc_check.
module can_test_frame_checker_unit
    import ctfc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctfc_in_if.sink       i_item,
    ctfc_out_if.source    o_result
);

    // The request register isolates the incoming channel. Its ready depends on
    // whether it is empty or the held request moves into the check stage this
    // cycle, so one more request is taken while a result still waits downstream.
    t_stage stage;
    logic   advance;

    ctfc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_stage   (stage)
    );

    // The check stage tracks the open frame: a header either reports at once
    // (length over the limit, or zero length) or opens a frame; each data byte
    // folds its low seven bits into the XOR, and the last byte closes the frame
    // and loads the status into the result register. Data bytes with no open
    // frame are consumed without a result, and a new header drops any frame
    // that was still open.
    ctfc_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .o_advance (advance),
        .o_result  (o_result)
    );

endmodule

/* rtl/ctfc_checker.sv */
// Port-level assertions for the CAN test frame checker, bound to the top level.
// Uses ctfc_pkg for the status codes.
module ctfc_checker
    import ctfc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_check_status,
    input logic       i_frame_good
);

    // A reset cycle leaves no result on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // The good flag agrees with the status code.
    a_good_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_frame_good == (i_check_status == ST_OK)))
        else $error("frame_good disagrees with check_status");

    // Only defined status codes are reported.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_check_status <= ST_ID_TOP))
        else $error("undefined status code");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_check_status))
        else $error("stalled result changed");

endmodule

bind can_test_frame_checker_unit ctfc_checker u_ctfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_check_status (o_result.check_status),
    .i_frame_good   (o_result.frame_good)
);

/* dv/can_test_frame_checker_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for can_test_frame_checker_unit: directed table, then random frames.
// Depends on ctfc_pkg, the ctfc_in_if/ctfc_out_if interfaces and the unit itself.
module can_test_frame_checker_unit_tb;
    import ctfc_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1270;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One row of the directed table. A data row may repeat its byte several
    // times so that long frames fit in a few rows. Where has_status is set, the
    // status is typed in by hand instead of taken from the predictor.
    typedef struct {
        t_opcode     op;
        logic [28:0] ident;
        logic [7:0]  len;
        logic        ext;
        logic [7:0]  pbyte;
        int          reps;
        bit          has_status;
        t_status     status;
    } t_row;

    typedef struct {
        t_status status;
        logic    good;
    } t_verdict;

    typedef struct {
        bit      emits;
        t_status status;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    ctfc_in_if  item_if ();
    ctfc_out_if result_if ();

    can_test_frame_checker_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .o_result (result_if.source)
    );

    // Verdicts that the predictor has produced and the block still owes.
    t_verdict verdict_q[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       item_count     = 0;
    int       ready_hold     = 0;
    bit       quiet          = 1'b0;

    // Side information that travels with the request being driven.
    bit      row_has_status = 1'b0;
    t_status row_status     = ST_OK;

    // The predictor's copy of the frame being collected.
    logic [28:0] open_ident  = '0;
    logic [6:0]  open_len    = '0;
    logic        open_ext    = 1'b0;
    logic [6:0]  left_count  = '0;
    logic [6:0]  running_xor = '0;
    logic        in_frame    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // CAN FD length to DLC. Lengths that are not legal sizes fall into the
    // coarse buckets below; several of them map back to zero.
    function automatic logic [3:0] dlc_of_length(input logic [6:0] n);
        if (n < 7'd8)  return n[3:0];
        if (n < 7'd12) return 4'd8;
        if (n < 7'd16) return 4'd9;
        if (n < 7'd20) return 4'd10;
        if (n < 7'd24) return 4'd11;
        if (n < 7'd28) return 4'd12;
        if (n < 7'd32) return 4'd0;
        if (n < 7'd36) return 4'd13;
        if (n < 7'd48) return 4'd0;
        if (n < 7'd52) return 4'd14;
        if (n < 7'd64) return 4'd0;
        if (n < 7'd68) return 4'd15;
        return 4'd0;
    endfunction

    // The checks run in a fixed order and the first failure names the status.
    function automatic t_status judge_frame(input logic [28:0] id, input logic [6:0] n,
                                            input logic ext, input logic [6:0] x);
        if (id[6:0] != x)                  return ST_CHECKSUM;
        if (id[10:7] != dlc_of_length(n))  return ST_DLC;
        if (!ext)                          return ST_OK;
        if (id[21:11] != id[10:0])         return ST_ID_MID;
        if (id[28:22] != id[6:0])          return ST_ID_TOP;
        return ST_OK;
    endfunction

    // Advances the predictor by one accepted request.
    function automatic t_outcome predict_frame(input t_item it);
        t_outcome res;
        res.emits  = 1'b0;
        res.status = ST_OK;
        if (it.opcode == OP_HEADER) begin
            // A new header always drops whatever frame was still being collected.
            in_frame = 1'b0;
            if (it.data_length > 8'(MAX_PAYLOAD)) begin
                res.emits  = 1'b1;
                res.status = ST_LENGTH;
            end else if (it.data_length == 8'd0) begin
                res.emits  = 1'b1;
                res.status = judge_frame(it.frame_ident, 7'd0, it.extended_frame, 7'd0);
            end else begin
                open_ident  = it.frame_ident;
                open_len    = it.data_length[6:0];
                open_ext    = it.extended_frame;
                left_count  = it.data_length[6:0];
                running_xor = '0;
                in_frame    = 1'b1;
            end
        end else if (in_frame) begin
            running_xor = running_xor ^ it.payload_byte[6:0];
            left_count  = left_count - 7'd1;
            if (left_count == 7'd0) begin
                in_frame   = 1'b0;
                res.emits  = 1'b1;
                res.status = judge_frame(open_ident, open_len, open_ext, running_xor);
            end
        end
        return res;
    endfunction

    // Both sides sample at the rising edge. Requests feed the predictor and
    // results are compared with the oldest verdict still owed.
    always @(posedge i_clk) begin
        t_item    it;
        t_outcome res;
        t_verdict want;
        if (i_rst_n && item_if.valid && item_if.ready) begin
            it.opcode         = item_if.opcode;
            it.frame_ident    = item_if.frame_ident;
            it.data_length    = item_if.data_length;
            it.extended_frame = item_if.extended_frame;
            it.payload_byte   = item_if.payload_byte;
            res = predict_frame(it);
            if (res.emits) begin
                want.status = row_has_status ? row_status : res.status;
                want.good   = (want.status == ST_OK);
                verdict_q.push_back(want);
            end
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result: check_status %0d, frame_good %0b",
                       result_if.check_status, result_if.frame_good);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                if (result_if.check_status !== want.status) begin
                    $error("check_status: expected %0d, got %0d",
                           want.status, result_if.check_status);
                    mismatch_count++;
                end
                if (result_if.frame_good !== want.good) begin
                    $error("frame_good: expected %0b, got %0b",
                           want.good, result_if.frame_good);
                    mismatch_count++;
                end
            end
        end
    end

    // The run is cut off if it goes on far longer than any correct run could.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("can_test_frame_checker_unit regression: fail");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    // The result side stalls in bursts of random length, except in quiet stretches.
    always @(negedge i_clk) begin
        if (quiet) begin
            ready_hold = 0;
        end else if (ready_hold == 0 && $urandom_range(0, 99) < 20) begin
            ready_hold = pick_gap();
        end
        if (ready_hold > 0) begin
            result_if.ready <= 1'b0;
            ready_hold--;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // Drives one request at the falling edge, after a random gap, and holds it
    // until the block takes it. valid stays high when the next request follows
    // with no gap.
    task automatic send_item(input t_item it, input bit has_status, input t_status st);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            item_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.opcode         = it.opcode;
        item_if.frame_ident    = it.frame_ident;
        item_if.data_length    = it.data_length;
        item_if.extended_frame = it.extended_frame;
        item_if.payload_byte   = it.payload_byte;
        row_has_status         = has_status;
        row_status             = st;
        item_if.valid          = 1'b1;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    // Header request with random filler in the byte field.
    task automatic send_header(input logic [28:0] id, input logic [7:0] n, input logic ext);
        t_item it;
        it.opcode         = OP_HEADER;
        it.frame_ident    = id;
        it.data_length    = n;
        it.extended_frame = ext;
        it.payload_byte   = 8'($urandom_range(0, 255));
        send_item(it, 1'b0, ST_OK);
    endtask

    // Data request with random filler in the header fields.
    task automatic send_byte(input logic [7:0] b);
        t_item it;
        it.opcode         = OP_DATA;
        it.frame_ident    = 29'($urandom());
        it.data_length    = 8'($urandom_range(0, 255));
        it.extended_frame = 1'($urandom_range(0, 1));
        it.payload_byte   = b;
        send_item(it, 1'b0, ST_OK);
    endtask

    // One random frame. Most frames are built to pass, with random content,
    // and then some of them get a single flaw so that every check fires.
    // Stray bytes, over-length headers and cut-off frames make up the rest.
    task automatic run_frame();
        int          kind;
        int          flaw;
        int          r;
        int          sent;
        logic [7:0]  n;
        logic [7:0]  bytes[$];
        logic [6:0]  x;
        logic [28:0] id;
        logic        ext;
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            // Only a byte with no frame open is ignored; otherwise it counts.
            if (in_frame) item_count++;
            send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 12) begin
            send_header(29'($urandom()), 8'($urandom_range(65, 255)), 1'($urandom_range(0, 1)));
            item_count++;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 10)      n = 8'd0;
            else if (r < 60) n = 8'($urandom_range(1, 8));
            else if (r < 85) n = 8'($urandom_range(9, 24));
            else if (r < 95) n = 8'($urandom_range(25, 63));
            else             n = 8'(MAX_PAYLOAD);
            ext = 1'($urandom_range(0, 1));
            x   = '0;
            for (int k = 0; k < n; k++) begin
                bytes.push_back(8'($urandom_range(0, 255)));
                x = x ^ bytes[k][6:0];
            end
            id        = 29'($urandom());
            id[6:0]   = x;
            id[10:7]  = dlc_of_length(n[6:0]);
            if (ext) begin
                id[21:11] = id[10:0];
                id[28:22] = id[6:0];
            end
            flaw = $urandom_range(0, 99);
            sent = n;
            if (flaw < 60)      ;
            else if (flaw < 70) id = id ^ (29'd1 << $urandom_range(0, 6));
            else if (flaw < 78) id = id ^ (29'd1 << $urandom_range(7, 10));
            else if (flaw < 86) id = id ^ (29'd1 << $urandom_range(11, 21));
            else if (flaw < 94) id = id ^ (29'd1 << $urandom_range(22, 28));
            else if (n > 1)     sent = $urandom_range(1, n - 1);
            send_header(id, n, ext);
            item_count++;
            for (int k = 0; k < sent; k++) begin
                send_byte(bytes[k]);
                item_count++;
            end
        end
    endtask

    // Directed table: reset behavior, length extremes, every status code,
    // invalid length codes, a header that cuts a frame short and stray bytes.
    t_row directed[] = '{
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'hff, 1,  1'b0, ST_OK},
        '{OP_HEADER, 29'h0,        8'd0,   1'b0, 8'h00, 1,  1'b1, ST_OK},
        '{OP_HEADER, 29'h0,        8'd65,  1'b0, 8'h00, 1,  1'b1, ST_LENGTH},
        '{OP_HEADER, 29'h1fffffff, 8'd255, 1'b1, 8'hff, 1,  1'b1, ST_LENGTH},
        '{OP_HEADER, 29'h1,        8'd0,   1'b0, 8'h00, 1,  1'b1, ST_CHECKSUM},
        '{OP_HEADER, 29'h0,        8'd0,   1'b1, 8'h00, 1,  1'b1, ST_OK},
        '{OP_HEADER, 29'h780,      8'd0,   1'b0, 8'h00, 1,  1'b1, ST_DLC},
        '{OP_HEADER, 29'h800,      8'd0,   1'b1, 8'h00, 1,  1'b1, ST_ID_MID},
        '{OP_HEADER, 29'h400000,   8'd0,   1'b1, 8'h00, 1,  1'b1, ST_ID_TOP},
        '{OP_HEADER, 29'h800,      8'd0,   1'b0, 8'h00, 1,  1'b1, ST_OK},
        '{OP_HEADER, 29'hd5,       8'd1,   1'b0, 8'h00, 1,  1'b0, ST_OK},
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'hd5, 1,  1'b0, ST_OK},
        '{OP_HEADER, 29'h3c0780,   8'd64,  1'b1, 8'h00, 1,  1'b0, ST_OK},
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'ha5, 64, 1'b0, ST_OK},
        '{OP_HEADER, 29'h4b3,      8'd13,  1'b0, 8'h00, 1,  1'b0, ST_OK},
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'h33, 13, 1'b0, ST_OK},
        '{OP_HEADER, 29'h0,        8'd28,  1'b0, 8'h00, 1,  1'b0, ST_OK},
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'h80, 28, 1'b0, ST_OK},
        '{OP_HEADER, 29'h1fffffff, 8'd5,   1'b1, 8'h00, 1,  1'b0, ST_OK},
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'h01, 2,  1'b0, ST_OK},
        '{OP_HEADER, 29'h0,        8'd0,   1'b0, 8'h00, 1,  1'b1, ST_OK},
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'h7f, 1,  1'b0, ST_OK},
        '{OP_HEADER, 29'h100,      8'd2,   1'b0, 8'h00, 1,  1'b0, ST_OK},
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'h7f, 1,  1'b0, ST_OK},
        '{OP_DATA,   29'h0,        8'd0,   1'b0, 8'h00, 1,  1'b0, ST_OK}
    };

    initial begin
        t_item it;
        // Every input is known from time zero; reset is held low first, then released at a falling edge.
        i_rst_n                = 1'b0;
        item_if.valid          = 1'b0;
        item_if.opcode         = OP_HEADER;
        item_if.frame_ident    = '0;
        item_if.data_length    = '0;
        item_if.extended_frame = 1'b0;
        item_if.payload_byte   = '0;
        result_if.ready        = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            for (int k = 0; k < directed[i].reps; k++) begin
                it.opcode         = directed[i].op;
                it.frame_ident    = directed[i].ident;
                it.data_length    = directed[i].len;
                it.extended_frame = directed[i].ext;
                it.payload_byte   = directed[i].pbyte;
                send_item(it, directed[i].has_status, directed[i].status);
            end
        end

        // Random part, with a stretch of back-to-back traffic every few hundred
        // requests so that the block also sees full rate on both sides.
        while (item_count < RANDOM_ITEMS) begin
            quiet = ((item_count / 150) % 4 == 1);
            run_frame();
        end
        quiet = 1'b0;
        @(negedge i_clk);
        item_if.valid = 1'b0;

        // Let every owed result arrive, then give a stray one time to show up.
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("can_test_frame_checker_unit regression: pass");
        end else begin
            $display("can_test_frame_checker_unit regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ctfc_pkg.sv
rtl/ctfc_if.sv
rtl/ctfc_in_reg.sv
rtl/ctfc_check.sv
rtl/can_test_frame_checker_unit.sv
rtl/ctfc_checker.sv
dv/can_test_frame_checker_unit_tb.sv
